// ===== rtl/sitrd_pkg.sv =====
package sitrd_pkg;

  localparam int MAX_RADIX_DEF  = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int SYM_W       = 8;
  localparam int NUM_SYMS    = 16;
  localparam int SYM_IDX_W   = 4;
  localparam int RADIX_W     = 5;
  localparam int SYM_BANK_W  = 64;
  localparam int SYM_TAB_W   = 2 * SYM_BANK_W;
  localparam int CFG_IDX_W   = 2;
  localparam int DIV_STEP    = 4;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic neg;
    logic div_last;
    logic digits_done;
    logic last_digit;
    logic slot_free;
  } dp_status_t;

  function automatic logic [SYM_W-1:0] sym_at(input logic [SYM_TAB_W-1:0] sym_tab,
                                              input logic [SYM_IDX_W-1:0] idx);
    return sym_tab[{idx, 3'b000} +: SYM_W];
  endfunction

  function automatic logic base_ok(input logic [RADIX_W-1:0] n,
                                   input logic [SYM_TAB_W-1:0] sym_tab,
                                   input int max_radix);
    logic             ok;
    logic [SYM_W-1:0] a;
    ok = (n >= RADIX_W'(2)) && (int'(n) <= max_radix);
    for (int i = 0; i < NUM_SYMS; i++) begin
      a = sym_at(sym_tab, SYM_IDX_W'(i));
      if (i < int'(n)) begin
        if (a == SYM_PLUS || a == SYM_MINUS) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < NUM_SYMS; j++) begin
          if (j < int'(n) && a == sym_at(sym_tab, SYM_IDX_W'(j))) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

endpackage

// ===== rtl/signed_integer_to_radix_digits.sv =====
// After an item is accepted, its first beat leaves once the controller has passed through
// the base check, then the divider for each digit (4 quotient bits per cycle over the
// 32-bit magnitude), and the output register has been loaded.
// Without output stalls the characters, a sign first if negative, leave at one per cycle;
// a new item is accepted only after the last character of the previous one is emitted.
// Synchronous active-low reset clears the configuration (an invalid base) and idles.
module signed_integer_to_radix_digits #(
  parameter int MAX_RADIX  = sitrd_pkg::MAX_RADIX_DEF,
  parameter int VALUE_BITS = sitrd_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // Bits from the lowest: value, then zero padding to whole bytes.
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // Bits from the lowest: symbol.
  output logic [sitrd_pkg::SYM_W-1:0]           out_tdata,
  output logic                                  out_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sitrd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sitrd_pkg::SYM_BANK_W-1:0]      cfg_data
);

  logic [sitrd_pkg::RADIX_W-1:0]   radix;
  logic [sitrd_pkg::SYM_TAB_W-1:0] sym_tab;
  logic                            base_valid;
  sitrd_pkg::dp_cmd_t              cmd;
  sitrd_pkg::dp_status_t           status;

  sitrd_cfg #(
    .MAX_RADIX (MAX_RADIX)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .radix      (radix),
    .sym_tab    (sym_tab),
    .base_valid (base_valid)
  );

  sitrd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .base_valid (base_valid),
    .status     (status),
    .cmd        (cmd)
  );

  sitrd_dp #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_value   (in_tdata[VALUE_BITS-1:0]),
    .radix      (radix),
    .sym_tab    (sym_tab),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/sitrd_cfg.sv =====
module sitrd_cfg #(
  parameter int MAX_RADIX = sitrd_pkg::MAX_RADIX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sitrd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sitrd_pkg::SYM_BANK_W-1:0]        cfg_data,
  output logic [sitrd_pkg::RADIX_W-1:0]           radix,
  output logic [sitrd_pkg::SYM_TAB_W-1:0]         sym_tab,
  output logic                                   base_valid
);

  logic [sitrd_pkg::RADIX_W-1:0]    base_length_r;
  logic [sitrd_pkg::SYM_BANK_W-1:0] symbols_low_r;
  logic [sitrd_pkg::SYM_BANK_W-1:0] symbols_high_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_length_r  <= '0;
      symbols_low_r  <= '0;
      symbols_high_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sitrd_pkg::CFG_BASE_LENGTH:  base_length_r  <= cfg_data[sitrd_pkg::RADIX_W-1:0];
        sitrd_pkg::CFG_SYMBOLS_LOW:  symbols_low_r  <= cfg_data;
        sitrd_pkg::CFG_SYMBOLS_HIGH: symbols_high_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign radix      = base_length_r;
  assign sym_tab    = {symbols_high_r, symbols_low_r};
  assign base_valid = sitrd_pkg::base_ok(base_length_r, sym_tab, MAX_RADIX);

endmodule

// ===== rtl/sitrd_ctrl.sv =====
module sitrd_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic                    base_valid,
  input  sitrd_pkg::dp_status_t   status,
  output sitrd_pkg::dp_cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = base_valid ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last && status.digits_done) begin
          state_nxt = status.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (status.slot_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (status.slot_free) begin
          cmd.emit_digit = 1'b1;
          if (status.last_digit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sitrd_dp.sv =====
module sitrd_dp #(
  parameter int MAX_RADIX  = sitrd_pkg::MAX_RADIX_DEF,
  parameter int VALUE_BITS = sitrd_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sitrd_pkg::dp_cmd_t                cmd,
  output sitrd_pkg::dp_status_t             status,
  input  logic [VALUE_BITS-1:0]             in_value,
  input  logic [sitrd_pkg::RADIX_W-1:0]     radix,
  input  logic [sitrd_pkg::SYM_TAB_W-1:0]   sym_tab,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sitrd_pkg::SYM_W-1:0]       out_tdata,
  output logic                              out_tlast
);

  localparam int STEP  = sitrd_pkg::DIV_STEP;
  localparam int MAG_W = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
  localparam int STEPS = MAG_W / STEP;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int RAD_W = $clog2(MAX_RADIX + 1);
  localparam int DIG_W = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
  localparam int ND_W  = $clog2(VALUE_BITS + 1);

  logic [MAG_W-1:0]             mag_r;
  logic [MAG_W-1:0]             mag_nxt;
  logic [RAD_W-1:0]             rem_r;
  logic [RAD_W-1:0]             rem_nxt;
  logic [CNT_W-1:0]             cnt_r;
  logic [ND_W-1:0]              nd_r;
  logic                         neg_r;
  logic [DIG_W-1:0]             stack_r [VALUE_BITS];
  logic                         out_valid_r;
  logic [sitrd_pkg::SYM_W-1:0]  out_sym_r;
  logic                         out_last_r;
  logic [RAD_W:0]               rad_ext;
  logic [VALUE_BITS-1:0]        abs_value;
  logic                         push;

  assign rad_ext   = (RAD_W + 1)'(radix);
  assign abs_value = in_value[VALUE_BITS-1] ? (VALUE_BITS'(0) - in_value) : in_value;

  // Restoring division that retires STEP quotient bits per cycle in place.
  always_comb begin
    logic [RAD_W:0]   r;
    logic [MAG_W-1:0] m;
    r = {1'b0, rem_r};
    m = mag_r;
    for (int s = 0; s < STEP; s++) begin
      r = {r[RAD_W-1:0], m[MAG_W-1]};
      m = {m[MAG_W-2:0], 1'b0};
      if (r >= rad_ext) begin
        r    = r - rad_ext;
        m[0] = 1'b1;
      end
    end
    rem_nxt = r[RAD_W-1:0];
    mag_nxt = m;
  end

  assign push = cmd.div_step && status.div_last;

  assign status.neg         = neg_r;
  assign status.div_last    = (cnt_r == CNT_W'(STEPS - 1));
  assign status.digits_done = (mag_nxt == '0) || (nd_r == ND_W'(VALUE_BITS - 1));
  assign status.last_digit  = (nd_r == ND_W'(1));
  assign status.slot_free   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      nd_r  <= '0;
      rem_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
      nd_r  <= '0;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (status.div_last) begin
        cnt_r <= '0;
        rem_r <= '0;
        nd_r  <= nd_r + ND_W'(1);
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
        rem_r <= rem_nxt;
      end
    end else if (cmd.emit_digit) begin
      nd_r <= nd_r - ND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= MAG_W'(abs_value);
      neg_r <= in_value[VALUE_BITS-1];
    end else if (cmd.div_step) begin
      mag_r <= mag_nxt;
    end
  end

  // The digit stack is last in, first out, so digits leave most significant first.
  always_ff @(posedge clk) begin
    if (push) begin
      stack_r[0] <= rem_nxt[DIG_W-1:0];
      for (int i = 1; i < VALUE_BITS; i++) begin
        stack_r[i] <= stack_r[i-1];
      end
    end else if (cmd.emit_digit) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stack_r[i] <= stack_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_sym_r  <= sitrd_pkg::SYM_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_sym_r  <= sitrd_pkg::sym_at(sym_tab, sitrd_pkg::SYM_IDX_W'(stack_r[0]));
      out_last_r <= status.last_digit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== sim/signed_integer_to_radix_digits_tb.sv =====
`timescale 1ns / 1ps

module signed_integer_to_radix_digits_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam logic [sitrd_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [15:0] STALL_PATTERN = 16'b1101_0011_1110_0101;

  typedef struct packed {
    logic [sitrd_pkg::SYM_W-1:0] sym;
    logic                        last;
  } glyph_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [31:0]                     in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [sitrd_pkg::SYM_W-1:0]     out_tdata;
  logic                            out_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [sitrd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sitrd_pkg::SYM_BANK_W-1:0] cfg_data = '0;

  logic [sitrd_pkg::RADIX_W-1:0]   radix_len = '0;
  logic [sitrd_pkg::SYM_TAB_W-1:0] sym_tab = '0;

  logic [31:0] value_q[$];
  glyph_t      text_q[$];
  int          queued_cnt = 0;
  int          accepted_cnt = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          gap_mode = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_mode = 0;
  int          stall_pos = 0;
  int          hold_reqs = 0;
  int          holds_done = 0;
  int          hold_left = 0;

  signed_integer_to_radix_digits dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit base_usable();
    logic [sitrd_pkg::SYM_W-1:0] a;
    if (radix_len < 2 || radix_len > sitrd_pkg::MAX_RADIX_DEF) return 1'b0;
    for (int i = 0; i < int'(radix_len); i++) begin
      a = sym_tab[i*8 +: 8];
      if (a == sitrd_pkg::SYM_PLUS || a == sitrd_pkg::SYM_MINUS) return 1'b0;
      for (int j = i + 1; j < int'(radix_len); j++) begin
        if (sym_tab[j*8 +: 8] == a) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void render_value(input logic [31:0] v);
    logic [31:0] mag;
    logic [31:0] radix;
    int          digs[$];
    if (!base_usable()) return;
    radix = 32'(radix_len);
    mag = v[31] ? -v : v;
    do begin
      digs.push_front(int'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    if (v[31]) text_q.push_back('{sitrd_pkg::SYM_MINUS, 1'b0});
    foreach (digs[i]) begin
      text_q.push_back('{sym_tab[digs[i]*8 +: 8], 1'(i == digs.size() - 1)});
    end
  endfunction

  always @(posedge clk) begin : sender
    logic nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nxt = in_tvalid;
      if (in_tvalid && in_tready) begin
        render_value(in_tdata);
        accepted_cnt++;
        nxt = 1'b0;
      end
      if (!nxt) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (value_q.size() > 0) begin
          in_tdata <= value_q.pop_front();
          nxt = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else if (gap_mode != 0) begin
            burst_left = $urandom_range(0, 15);
            gap_left = $urandom_range(1, 12);
          end
        end
      end
      in_tvalid <= nxt;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_done != hold_reqs) begin
      holds_done++;
      hold_left = HOLD_OFF_CYCLES;
      out_tready <= 1'b0;
    end else begin
      stall_pos = (stall_pos + 1) % 16;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= STALL_PATTERN[stall_pos];
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : receiver_check
    glyph_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (text_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected beat: symbol %h last %b", out_tdata, out_tlast);
        end
      end else begin
        want = text_q.pop_front();
        if (out_tdata !== want.sym || out_tlast !== want.last) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch: expected symbol %h last %b, got symbol %h last %b",
                     want.sym, want.last, out_tdata, out_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [sitrd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sitrd_pkg::SYM_BANK_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      sitrd_pkg::CFG_BASE_LENGTH: radix_len = data[sitrd_pkg::RADIX_W-1:0];
      sitrd_pkg::CFG_SYMBOLS_LOW: sym_tab[sitrd_pkg::SYM_BANK_W-1:0] = data;
      sitrd_pkg::CFG_SYMBOLS_HIGH:
        sym_tab[sitrd_pkg::SYM_TAB_W-1:sitrd_pkg::SYM_BANK_W] = data;
      default: ;
    endcase
  endtask

  task automatic set_base(input int len, input logic [sitrd_pkg::SYM_TAB_W-1:0] tab);
    logic [sitrd_pkg::SYM_BANK_W-1:0] lw;
    lw = {$urandom, $urandom};
    lw[sitrd_pkg::RADIX_W-1:0] = sitrd_pkg::RADIX_W'(len);
    write_reg(sitrd_pkg::CFG_BASE_LENGTH, lw);
    write_reg(sitrd_pkg::CFG_SYMBOLS_LOW, tab[sitrd_pkg::SYM_BANK_W-1:0]);
    write_reg(sitrd_pkg::CFG_SYMBOLS_HIGH,
              tab[sitrd_pkg::SYM_TAB_W-1:sitrd_pkg::SYM_BANK_W]);
    stall_mode = $urandom_range(0, 3);
    gap_mode = $urandom_range(0, 1);
  endtask

  function automatic logic [sitrd_pkg::SYM_TAB_W-1:0] table_from_text(input string s);
    logic [sitrd_pkg::SYM_TAB_W-1:0] t;
    t = {sitrd_pkg::NUM_SYMS{sitrd_pkg::SYM_MINUS}};
    for (int i = 0; i < s.len(); i++) t[i*8 +: 8] = s[i];
    return t;
  endfunction

  function automatic logic [sitrd_pkg::SYM_TAB_W-1:0] random_table(input int len);
    logic [sitrd_pkg::SYM_TAB_W-1:0] t;
    logic [sitrd_pkg::SYM_W-1:0]     b;
    bit                              dup;
    t = '0;
    for (int i = 0; i < sitrd_pkg::NUM_SYMS; i++) begin
      if (i >= len) begin
        t[i*8 +: 8] = 8'($urandom);
      end else begin
        do begin
          b = 8'($urandom);
          dup = (b == sitrd_pkg::SYM_PLUS || b == sitrd_pkg::SYM_MINUS);
          for (int j = 0; j < i; j++) if (t[j*8 +: 8] == b) dup = 1'b1;
        end while (dup);
        t[i*8 +: 8] = b;
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    int          k;
    k = $urandom_range(0, 9);
    if (k < 4) begin
      v = $urandom;
    end else if (k < 6) begin
      v = $urandom_range(0, 600) - 300;
    end else if (k < 8) begin
      v = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      case ($urandom_range(0, 3))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        2: v = 32'h0000_0000;
        default: v = 32'hFFFF_FFFF;
      endcase
    end
    return v;
  endfunction

  task automatic push_value(input logic [31:0] v);
    value_q.push_back(v);
    queued_cnt++;
  endtask

  task automatic push_random(input int n);
    repeat (n) push_value(random_value());
  endtask

  task automatic settle();
    while (accepted_cnt != queued_cnt || text_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [sitrd_pkg::SYM_TAB_W-1:0] tab;
    int                              len;
    int                              pick;
    int                              slot;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers still hold their reset values, which is not a usable base.
    push_value(32'd0);
    push_value(32'hFFFF_FFFF);
    settle();

    set_base(10, table_from_text("0123456789"));
    push_value(32'd0);
    push_value(32'hFFFF_FFFF);
    push_value(32'd9);
    push_value(32'd10);
    push_value(32'h7FFF_FFFF);
    push_value(32'h8000_0000);
    push_random(60);
    settle();

    tab = table_from_text("01");
    tab[sitrd_pkg::SYM_TAB_W-1:sitrd_pkg::SYM_BANK_W] = '1;
    set_base(2, tab);
    stall_mode = 1;
    gap_mode = 0;
    hold_reqs++;
    push_value(32'h8000_0000);
    push_value(32'h7FFF_FFFF);
    push_random(40);
    settle();

    set_base(16, table_from_text("0123456789ABCDEF"));
    hold_reqs++;
    push_value(32'd15);
    push_value(32'hFFFF_FFF0);
    push_value(32'hDEAD_BEEF);
    push_random(50);
    settle();

    tab = random_table(16);
    tab[7:0] = 8'h00;
    tab[15*8 +: 8] = 8'hFF;
    for (int i = 1; i < 15; i++) begin
      if (tab[i*8 +: 8] == 8'h00 || tab[i*8 +: 8] == 8'hFF) tab[i*8 +: 8] = 8'h30 + 8'(i);
    end
    set_base(16, tab);
    push_random(50);
    settle();

    write_reg(CFG_UNMAPPED, {$urandom, $urandom});
    push_value(random_value());
    settle();

    // Broken tables: repeat in the last slot, signs in first and last slots; then lengths 1, 17, 31.
    tab = random_table(5);
    tab[4*8 +: 8] = tab[7:0];
    set_base(5, tab);
    push_value(32'd1234);
    settle();
    tab = random_table(7);
    tab[6*8 +: 8] = sitrd_pkg::SYM_PLUS;
    set_base(7, tab);
    push_value(32'hFFFF_FF00);
    settle();
    tab = random_table(12);
    tab[7:0] = sitrd_pkg::SYM_MINUS;
    set_base(12, tab);
    push_value(32'd77);
    settle();
    set_base(1, random_table(1));
    push_value(32'd0);
    settle();
    set_base(17, random_table(16));
    push_value(32'd5);
    settle();
    set_base(31, random_table(16));
    push_value(32'h8000_0000);
    settle();

    repeat (8) begin
      len = $urandom_range(2, 16);
      tab = random_table(len);
      pick = $urandom_range(0, 9);
      if (pick == 7) begin
        slot = $urandom_range(1, len - 1);
        tab[slot*8 +: 8] = tab[$urandom_range(0, slot - 1)*8 +: 8];
      end else if (pick == 8) begin
        tab[$urandom_range(0, len - 1)*8 +: 8] =
          $urandom_range(0, 1) ? sitrd_pkg::SYM_PLUS : sitrd_pkg::SYM_MINUS;
      end else if (pick == 9) begin
        len = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
      end
      set_base(len, tab);
      push_random(20);
      settle();
    end

    err_cnt += text_q.size();
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
